FILE: sv/hms_pkg.sv
// ----------------------------------------------------------------------------
// hms_pkg: shared types and constants
// Parse phases, token kinds, directions, characters and the result record for the
// HTTP message splitter.
// ----------------------------------------------------------------------------
package hms_pkg;

  typedef enum logic [3:0] {
    PH_IDLE,
    PH_IGNORE,
    PH_LEAD,
    PH_TOK0,
    PH_GAP1,
    PH_TOK1,
    PH_GAP2,
    PH_TOK2,
    PH_HNAME,
    PH_HGAP,
    PH_HVAL,
    PH_BODY
  } phase_t;

  localparam logic [2:0] K_TOK0  = 3'd0;
  localparam logic [2:0] K_TOK1  = 3'd1;
  localparam logic [2:0] K_TOK2  = 3'd2;
  localparam logic [2:0] K_HNAME = 3'd3;
  localparam logic [2:0] K_HVAL  = 3'd4;
  localparam logic [2:0] K_HDONE = 3'd5;
  localparam logic [2:0] K_BODY  = 3'd6;

  localparam logic [1:0] DIR_NONE = 2'd0;
  localparam logic [1:0] DIR_REQ  = 2'd1;
  localparam logic [1:0] DIR_RESP = 2'd2;

  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_COLON = 8'h3A;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_TAB   = 8'h09;

  localparam int MAX_RES = 4;

  typedef struct packed {
    logic [2:0]  kind;
    logic        dir;
    logic [15:0] start;
    logic [15:0] stop;
    logic        ovf;
    logic        derr;
    logic        last;
  } res_t;

endpackage

FILE: sv/http_message_splitter_top.sv
// ----------------------------------------------------------------------------
// http_message_splitter_top: HTTP/1.x start line and header tokenizer
// Turns a byte stream of HTTP messages into token spans (offsets).
// ----------------------------------------------------------------------------
// One message byte enters per transfer and is parsed in the same cycle; the
// spans it closes (zero to four) go into an 8-entry result queue that drains
// one span per output transfer. The input accepts a byte every cycle while
// the queue has room for four more spans, so while out_tready is held high
// the sustained rate is one byte per cycle whenever bytes average at most one
// span each; otherwise the output port, one span per cycle, sets the limit.
module http_message_splitter_top
  import hms_pkg::*;
#(
  parameter int OFFSET_BITS = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [15:0] in_tdata,   // [7:0] data_byte, [8] first_byte, rest zero
  input  logic [1:0]  in_tuser,   // [0] byte_valid, [1] direction
  input  logic        in_tlast,   // last_byte
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [39:0] out_tdata,  // [15:0] span_start, [31:16] span_end,
                                  // [32] offset_overflow, [33] direction_error
  output logic [3:0]  out_tuser,  // [2:0] token_kind, [3] token_direction
  output logic        out_tlast   // run_last
);

  typedef logic [OFFSET_BITS-1:0] pos_t;

  typedef struct packed {
    phase_t     ph;
    pos_t       pos;
    pos_t       sbeg;
    pos_t       crpos;
    logic       crp;
    logic       lhc;
    logic       h09;
    logic [1:0] pdir;
    logic       dead;
    logic       ovf;
  } st_t;

  typedef struct packed {
    res_t [MAX_RES-1:0] r;
    logic [2:0]         n;
  } rb_t;

  function automatic logic [15:0] f_lo16(input pos_t v);
    logic [OFFSET_BITS+15:0] w;
    w = {16'b0, v};
    return w[15:0];
  endfunction

  function automatic logic f_in_start(input phase_t ph);
    return (ph == PH_LEAD) || (ph == PH_TOK0) || (ph == PH_GAP1) ||
           (ph == PH_TOK1) || (ph == PH_GAP2) || (ph == PH_TOK2);
  endfunction

  function automatic logic f_in_hdr(input phase_t ph);
    return (ph == PH_HNAME) || (ph == PH_HGAP) || (ph == PH_HVAL);
  endfunction

  function automatic void f_emit(inout st_t s, inout rb_t b, input logic [2:0] k,
                                 input pos_t a, input pos_t e);
    if (b.n < 3'(MAX_RES)) begin
      b.r[b.n[1:0]].kind  = k;
      b.r[b.n[1:0]].dir   = (s.pdir == DIR_RESP);
      b.r[b.n[1:0]].start = f_lo16(a);
      b.r[b.n[1:0]].stop  = f_lo16(e);
      b.r[b.n[1:0]].ovf   = s.ovf;
      b.r[b.n[1:0]].derr  = 1'b0;
      b.r[b.n[1:0]].last  = 1'b0;
      b.n = b.n + 3'd1;
      if (k == K_TOK2 && s.pdir == DIR_REQ) begin
        s.h09 = (a == e);
      end
    end
  endfunction

  function automatic void f_close_start(inout st_t s, inout rb_t b, input pos_t p);
    logic [1:0] k;
    k = 2'd0;
    case (s.ph)
      PH_TOK0: begin f_emit(s, b, K_TOK0, s.sbeg, p); k = 2'd1; end
      PH_GAP1: k = 2'd1;
      PH_TOK1: begin f_emit(s, b, K_TOK1, s.sbeg, p); k = 2'd2; end
      PH_GAP2: k = 2'd2;
      PH_TOK2: begin f_emit(s, b, K_TOK2, s.sbeg, p); k = 2'd3; end
      default: k = 2'd0;
    endcase
    for (int i = 0; i < 3; i++) begin
      if (2'(i) >= k) f_emit(s, b, 3'(i), p, p);
    end
  endfunction

  function automatic void f_close_hdr(inout st_t s, inout rb_t b, input pos_t p);
    if (s.ph == PH_HNAME) begin
      f_emit(s, b, K_HNAME, s.sbeg, p);
      f_emit(s, b, K_HVAL, p, p);
    end else if (s.ph == PH_HGAP) begin
      f_emit(s, b, K_HVAL, p, p);
    end else if (s.ph == PH_HVAL) begin
      f_emit(s, b, K_HVAL, s.sbeg, p);
    end
  endfunction

  function automatic void f_content(inout st_t s, inout rb_t b, input logic [7:0] c,
                                    input pos_t p);
    logic ws;
    logic fresh;
    ws    = (c == CH_SPACE) || (c >= CH_TAB && c <= CH_CR);
    fresh = !s.lhc;
    s.lhc = 1'b1;
    if (s.ph == PH_HNAME && fresh) s.sbeg = p;
    if (c[7]) begin
      if (f_in_start(s.ph)) f_close_start(s, b, p);
      else if (f_in_hdr(s.ph)) f_close_hdr(s, b, p);
      s.dead = 1'b1;
    end else begin
      case (s.ph)
        PH_LEAD: if (!ws) begin s.sbeg = p; s.ph = PH_TOK0; end
        PH_TOK0: if (c == CH_SPACE) begin
          f_emit(s, b, K_TOK0, s.sbeg, p); s.ph = PH_GAP1;
        end
        PH_GAP1: if (!ws) begin s.sbeg = p; s.ph = PH_TOK1; end
        PH_TOK1: if (c == CH_SPACE) begin
          f_emit(s, b, K_TOK1, s.sbeg, p); s.ph = PH_GAP2;
        end
        PH_GAP2: if (!ws) begin s.sbeg = p; s.ph = PH_TOK2; end
        PH_HNAME: if (c == CH_COLON) begin
          f_emit(s, b, K_HNAME, s.sbeg, p); s.ph = PH_HGAP;
        end
        PH_HGAP: if (!ws) begin s.sbeg = p; s.ph = PH_HVAL; end
        default: ;
      endcase
    end
  endfunction

  function automatic void f_line_end(inout st_t s, inout rb_t b, input pos_t ce,
                                     input pos_t nx);
    if (f_in_start(s.ph)) begin
      f_close_start(s, b, ce);
      s.lhc = 1'b0;
      if (s.pdir == DIR_REQ && s.h09) begin
        f_emit(s, b, K_HDONE, nx, nx);
        s.ph   = PH_BODY;
        s.sbeg = nx;
      end else begin
        s.ph = PH_HNAME;
      end
    end else if (f_in_hdr(s.ph)) begin
      if (!s.lhc) begin
        f_emit(s, b, K_HDONE, nx, nx);
        s.ph   = PH_BODY;
        s.sbeg = nx;
      end else begin
        f_close_hdr(s, b, ce);
        s.ph  = PH_HNAME;
        s.lhc = 1'b0;
      end
    end
  endfunction

  function automatic void f_feed(inout st_t s, inout rb_t b, input logic [7:0] c);
    pos_t p;
    if (&s.pos) begin
      s.ovf = 1'b1;
      p = s.pos;
    end else begin
      p = s.pos;
      s.pos = s.pos + pos_t'(1);
    end
    if (!(s.ph == PH_BODY || s.dead)) begin
      if (s.crp && c == CH_LF) begin
        s.crp = 1'b0;
        f_line_end(s, b, s.crpos, s.pos);
      end else begin
        if (s.crp) begin
          s.crp = 1'b0;
          f_content(s, b, CH_CR, s.crpos);
        end
        if (c == CH_LF) begin
          f_line_end(s, b, p, s.pos);
        end else if (c == CH_CR) begin
          s.crp   = 1'b1;
          s.crpos = p;
        end else begin
          f_content(s, b, c, p);
        end
      end
    end
  endfunction

  function automatic void f_finish(inout st_t s, inout rb_t b);
    pos_t p;
    p = s.pos;
    if (s.ph == PH_BODY) begin
      if (p > s.sbeg) f_emit(s, b, K_BODY, s.sbeg, p);
    end else if (s.dead) begin
      f_emit(s, b, K_HDONE, p, p);
    end else begin
      if (s.crp) begin
        s.crp = 1'b0;
        f_content(s, b, CH_CR, s.crpos);
      end
      if (f_in_start(s.ph)) f_line_end(s, b, p, p);
      if (f_in_hdr(s.ph)) begin
        if (s.lhc) f_close_hdr(s, b, p);
        f_emit(s, b, K_HDONE, p, p);
      end
    end
  endfunction

  st_t        st_r, st_nxt;
  rb_t        rb;
  res_t       q_r [8];
  logic [2:0] wr_ptr_r, rd_ptr_r;
  logic [3:0] cnt_r;
  logic       push, pop;

  logic [7:0] in_byte;
  logic       in_first, in_valid, in_dir;
  assign in_byte  = in_tdata[7:0];
  assign in_first = in_tdata[8];
  assign in_valid = in_tuser[0];
  assign in_dir   = in_tuser[1];

  // Parse one byte against the current state; collect the spans it closes.
  always_comb begin
    st_t s;
    rb_t b;
    logic done;
    s    = st_r;
    b    = '0;
    done = 1'b0;
    if (in_first) begin
      if (s.pdir == {1'b0, in_dir} + 2'd1) begin
        // repeated direction: report once, drop the rest of the message
        b.r[0].kind  = K_TOK0;
        b.r[0].dir   = in_dir;
        b.r[0].derr  = 1'b1;
        b.n          = 3'd1;
        s.ph         = in_tlast ? PH_IDLE : PH_IGNORE;
        done         = 1'b1;
      end else begin
        s.pdir  = {1'b0, in_dir} + 2'd1;
        s.pos   = '0;
        s.sbeg  = '0;
        s.crpos = '0;
        s.crp   = 1'b0;
        s.lhc   = 1'b0;
        s.dead  = 1'b0;
        s.ovf   = 1'b0;
        s.ph    = PH_LEAD;
        if (in_dir && s.h09) begin
          f_emit(s, b, K_HDONE, '0, '0);
          s.ph = PH_BODY;
        end
      end
    end
    if (!done) begin
      if (s.ph == PH_IGNORE) begin
        if (in_tlast) s.ph = PH_IDLE;
      end else if (s.ph != PH_IDLE) begin
        if (in_valid) f_feed(s, b, in_byte);
        if (in_tlast) begin
          f_finish(s, b);
          s.ph = PH_IDLE;
        end
      end
    end
    for (int i = 0; i < MAX_RES; i++) begin
      if (3'(i) == b.n - 3'd1) b.r[i].last = 1'b1;
    end
    st_nxt = s;
    rb     = b;
  end

  assign in_tready  = (cnt_r <= 4'(MAX_RES));
  assign push       = in_tvalid && in_tready;
  assign out_tvalid = (cnt_r != 4'd0);
  assign pop        = out_tvalid && out_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r     <= '{ph: PH_IDLE, pos: '0, sbeg: '0, crpos: '0, crp: 1'b0,
                    lhc: 1'b0, h09: 1'b0, pdir: DIR_NONE, dead: 1'b0, ovf: 1'b0};
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (push) begin
        st_r     <= st_nxt;
        wr_ptr_r <= wr_ptr_r + rb.n;
      end
      if (pop) rd_ptr_r <= rd_ptr_r + 3'd1;
      cnt_r <= cnt_r + (push ? {1'b0, rb.n} : 4'd0) - (pop ? 4'd1 : 4'd0);
    end
  end

  // Queue payload: write the new spans at consecutive slots.
  always_ff @(posedge clk) begin
    for (int i = 0; i < MAX_RES; i++) begin
      if (push && 3'(i) < rb.n) q_r[wr_ptr_r + 3'(i)] <= rb.r[i];
    end
  end

  res_t head;
  assign head      = q_r[rd_ptr_r];
  assign out_tdata = {6'b0, head.derr, head.ovf, head.stop, head.start};
  assign out_tuser = {head.dir, head.kind};
  assign out_tlast = head.last;

endmodule

FILE: sim/hms_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// hms_checker: span predictor and scoreboard
// Watches both streams of the HTTP message splitter, predicts the token
// spans of every accepted byte and compares them with the spans that leave.
// ----------------------------------------------------------------------------
module hms_checker
  import hms_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  input  logic        in_tready,
  input  logic [15:0] in_tdata,
  input  logic [1:0]  in_tuser,
  input  logic        in_tlast,
  input  logic        out_tvalid,
  input  logic        out_tready,
  input  logic [39:0] out_tdata,
  input  logic [3:0]  out_tuser,
  input  logic        out_tlast,
  output int          fail_count,
  output int          pending
);

  localparam longint unsigned OFS_MAX = (64'd1 << 16) - 1;

  phase_t          ph;
  longint unsigned bpos, sbeg, crpos;
  bit              crp, lhc, h09, ldead, ovf;
  logic [1:0]      pdir;

  res_t span_q[$];   // spans still owed by the block
  res_t item_q[$];   // spans of the byte being predicted

  function automatic void push_span(logic [2:0] kind, longint unsigned s,
                                    longint unsigned e);
    res_t r;
    if (item_q.size() >= MAX_RES) return;
    r.kind  = kind;
    r.dir   = (pdir == DIR_RESP);
    r.start = s[15:0];
    r.stop  = e[15:0];
    r.ovf   = ovf;
    r.derr  = 1'b0;
    r.last  = 1'b0;
    item_q = {item_q, r};
    if (kind == K_TOK2 && pdir == DIR_REQ) h09 = (s == e);
  endfunction

  function automatic bit in_start();
    return ph >= PH_LEAD && ph <= PH_TOK2;
  endfunction

  function automatic bit in_hdr();
    return ph >= PH_HNAME && ph <= PH_HVAL;
  endfunction

  function automatic void close_start(longint unsigned p);
    int k;
    k = 0;
    case (ph)
      PH_TOK0: begin push_span(K_TOK0, sbeg, p); k = 1; end
      PH_GAP1: k = 1;
      PH_TOK1: begin push_span(K_TOK1, sbeg, p); k = 2; end
      PH_GAP2: k = 2;
      PH_TOK2: begin push_span(K_TOK2, sbeg, p); k = 3; end
      default: ;
    endcase
    for (; k < 3; k++) push_span(k[2:0], p, p);
  endfunction

  function automatic void close_hdr(longint unsigned p);
    if (ph == PH_HNAME) begin
      push_span(K_HNAME, sbeg, p);
      push_span(K_HVAL, p, p);
    end else if (ph == PH_HGAP) begin
      push_span(K_HVAL, p, p);
    end else if (ph == PH_HVAL) begin
      push_span(K_HVAL, sbeg, p);
    end
  endfunction

  function automatic void take_char(logic [7:0] c, longint unsigned p);
    bit ws, fresh;
    ws = (c == CH_SPACE) || (c >= 8'd9 && c <= 8'd13);
    fresh = !lhc;
    lhc = 1'b1;
    if (ph == PH_HNAME && fresh) sbeg = p;
    if (c[7]) begin
      // non-ASCII: flush what is open, the rest of the message is dead
      if (in_start()) close_start(p);
      else if (in_hdr()) close_hdr(p);
      ldead = 1'b1;
      return;
    end
    case (ph)
      PH_LEAD: if (!ws) begin sbeg = p; ph = PH_TOK0; end
      PH_TOK0: if (c == CH_SPACE) begin push_span(K_TOK0, sbeg, p); ph = PH_GAP1; end
      PH_GAP1: if (!ws) begin sbeg = p; ph = PH_TOK1; end
      PH_TOK1: if (c == CH_SPACE) begin push_span(K_TOK1, sbeg, p); ph = PH_GAP2; end
      PH_GAP2: if (!ws) begin sbeg = p; ph = PH_TOK2; end
      PH_HNAME: if (c == CH_COLON) begin push_span(K_HNAME, sbeg, p); ph = PH_HGAP; end
      PH_HGAP: if (!ws) begin sbeg = p; ph = PH_HVAL; end
      default: ;
    endcase
  endfunction

  function automatic void end_line(longint unsigned ce, longint unsigned nxt);
    if (in_start()) begin
      close_start(ce);
      lhc = 1'b0;
      if (pdir == DIR_REQ && h09) begin
        push_span(K_HDONE, nxt, nxt);
        ph = PH_BODY;
        sbeg = nxt;
      end else begin
        ph = PH_HNAME;
      end
    end else if (in_hdr()) begin
      if (!lhc) begin
        push_span(K_HDONE, nxt, nxt);
        ph = PH_BODY;
        sbeg = nxt;
      end else begin
        close_hdr(ce);
        ph = PH_HNAME;
        lhc = 1'b0;
      end
    end
  endfunction

  function automatic void take_byte(logic [7:0] c);
    longint unsigned p;
    if (bpos >= OFS_MAX) begin
      ovf = 1'b1;
      bpos = OFS_MAX;
      p = bpos;
    end else begin
      p = bpos;
      bpos++;
    end
    if (ph == PH_BODY || ldead) return;
    if (crp) begin
      crp = 1'b0;
      if (c == CH_LF) begin
        end_line(crpos, bpos);
        return;
      end
      take_char(CH_CR, crpos);
    end
    if (c == CH_LF) begin
      end_line(p, bpos);
      return;
    end
    if (c == CH_CR) begin
      crp = 1'b1;
      crpos = p;
      return;
    end
    take_char(c, p);
  endfunction

  function automatic void end_msg();
    if (ph == PH_BODY) begin
      if (bpos > sbeg) push_span(K_BODY, sbeg, bpos);
      return;
    end
    if (ldead) begin
      push_span(K_HDONE, bpos, bpos);
      return;
    end
    if (crp) begin
      crp = 1'b0;
      take_char(CH_CR, crpos);
    end
    if (in_start()) end_line(bpos, bpos);
    if (in_hdr()) begin
      if (lhc) close_hdr(bpos);
      push_span(K_HDONE, bpos, bpos);
    end
  endfunction

  function automatic void predict(logic [7:0] c, bit vld, bit dir, bit first, bit last);
    res_t r;
    item_q.delete();
    if (first) begin
      if (pdir == {1'b0, dir} + 2'd1) begin
        r = '0;
        r.dir  = dir;
        r.derr = 1'b1;
        r.last = 1'b1;
        span_q = {span_q, r};
        ph = last ? PH_IDLE : PH_IGNORE;
        return;
      end
      pdir  = {1'b0, dir} + 2'd1;
      bpos  = 0;
      sbeg  = 0;
      crpos = 0;
      crp   = 1'b0;
      lhc   = 1'b0;
      ldead = 1'b0;
      ovf   = 1'b0;
      ph    = PH_LEAD;
      if (dir && h09) begin
        push_span(K_HDONE, 0, 0);
        ph = PH_BODY;
      end
    end
    if (ph == PH_IDLE) return;
    if (ph == PH_IGNORE) begin
      if (last) ph = PH_IDLE;
      return;
    end
    if (vld) take_byte(c);
    if (last) begin
      end_msg();
      ph = PH_IDLE;
    end
    if (item_q.size() > 0) item_q[item_q.size() - 1].last = 1'b1;
    foreach (item_q[i]) span_q = {span_q, item_q[i]};
  endfunction

  always @(posedge clk) begin
    res_t got, want;
    if (!rst_n) begin
      ph = PH_IDLE;
      bpos = 0; sbeg = 0; crpos = 0;
      crp = 0; lhc = 0; h09 = 0; ldead = 0; ovf = 0;
      pdir = DIR_NONE;
      span_q.delete();
      fail_count <= 0;
    end else begin
      if (out_tvalid && out_tready) begin
        got.kind  = out_tuser[2:0];
        got.dir   = out_tuser[3];
        got.start = out_tdata[15:0];
        got.stop  = out_tdata[31:16];
        got.ovf   = out_tdata[32];
        got.derr  = out_tdata[33];
        got.last  = out_tlast;
        if (span_q.size() == 0) begin
          $display("%0t: unexpected span, expected none, actual %p", $time, got);
          fail_count <= fail_count + 1;
        end else begin
          want = span_q.pop_front();
          if (got !== want) begin
            $display("%0t: span mismatch, expected %p, actual %p", $time, want, got);
            fail_count <= fail_count + 1;
          end
        end
      end
      if (in_tvalid && in_tready)
        predict(in_tdata[7:0], in_tuser[0], in_tuser[1], in_tdata[8], in_tlast);
    end
    pending <= span_q.size();
  end

endmodule

FILE: sim/tb_http_message_splitter_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_http_message_splitter_top: testbench for the HTTP message splitter
// Feeds directed and random HTTP messages byte by byte with random stalls on
// both streams; a checker beside the block predicts and compares the spans.
// ----------------------------------------------------------------------------
module tb_http_message_splitter_top
  import hms_pkg::*;
;

  localparam int CYCLE_LIMIT = 600000;
  localparam int DRAIN_CYCLES = 30;
  localparam int RANDOM_ITEMS = 420;

  logic        clk;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [15:0] in_tdata;   // [7:0] data_byte, [8] first_byte, rest zero
  logic [1:0]  in_tuser;   // [0] byte_valid, [1] direction
  logic        in_tlast;   // last_byte
  logic        out_tvalid;
  logic        out_tready;
  logic [39:0] out_tdata;  // [15:0] span_start, [31:16] span_end, [32] overflow, [33] dir error
  logic [3:0]  out_tuser;  // [2:0] token_kind, [3] token_direction
  logic        out_tlast;  // run_last

  int  fail_count;
  int  pending;
  int  cycles = 0;
  int  sent;
  bit  quiet;              // no idling on either side in the last stretch
  logic [7:0] msg_q[$];

  http_message_splitter_top dut (.*);

  hms_checker chk (.*);

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // Abort a hung run.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("[http_message_splitter_top] ERROR");
      $finish;
    end
  end

  // Receiver: stall in random bursts until the quiet stretch.
  initial begin
    int n;
    out_tready = 1'b0;
    @(posedge clk iff rst_n);
    forever begin
      if (!quiet && $urandom_range(0, 3) == 0) begin
        out_tready <= 1'b0;
        n = $urandom_range(1, 11);
      end else begin
        out_tready <= 1'b1;
        n = $urandom_range(1, 20);
      end
      repeat (n) @(posedge clk);
    end
  end

  // Drive one input transfer and hold it until accepted.
  task automatic send_item(logic [7:0] c, bit vld, bit dir, bit first, bit last);
    in_tdata  <= {7'd0, first, c};
    in_tuser  <= {dir, vld};
    in_tlast  <= last;
    in_tvalid <= 1'b1;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    sent++;
    if (!quiet && $urandom_range(0, 5) == 0) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 11)) @(posedge clk);
    end
  endtask

  task automatic push_str(string s);
    for (int i = 0; i < s.len(); i++) msg_q = {msg_q, s[i]};
  endtask

  // Send the queued message; sprinkle empty items in its middle now and then.
  task automatic send_msg(bit dir, bit gaps);
    int n;
    n = msg_q.size();
    if (n == 0) begin
      send_item(8'($urandom), 1'b0, dir, 1'b1, 1'b1);
      return;
    end
    for (int i = 0; i < n; i++) begin
      if (gaps && i > 0 && $urandom_range(0, 15) == 0)
        send_item(8'($urandom), 1'b0, 1'($urandom), 1'b0, 1'b0);
      send_item(msg_q[i], 1'b1, dir, i == 0, i == n - 1);
    end
    msg_q.delete();
  endtask

  task automatic push_tok(int len);
    string alpha;
    alpha = "GETPOSTHTP/1.0aZz-_9";
    for (int i = 0; i < len; i++)
      msg_q = {msg_q, alpha[$urandom_range(0, alpha.len() - 1)]};
  endtask

  task automatic push_eol();
    if ($urandom_range(0, 1)) msg_q = {msg_q, CH_CR};
    msg_q = {msg_q, CH_LF};
  endtask

  task automatic push_noise();
    repeat ($urandom_range(1, 8)) msg_q = {msg_q, 8'($urandom)};
  endtask

  // Build a random message: mostly well formed, some noise and truncation.
  task automatic build_msg(bit dir);
    if ($urandom_range(0, 2) == 0) msg_q = {msg_q, CH_SPACE};
    push_tok($urandom_range(0, 5));
    if ($urandom_range(0, 9) == 0) push_noise();
    msg_q = {msg_q, ($urandom_range(0, 4) == 0) ? CH_TAB : CH_SPACE};
    if ($urandom_range(0, 3) == 0) msg_q = {msg_q, CH_SPACE};
    push_tok($urandom_range(1, 4));
    msg_q = {msg_q, CH_SPACE};
    if (dir || $urandom_range(0, 3) != 0) push_tok($urandom_range(1, 6));
    push_eol();
    repeat ($urandom_range(0, 3)) begin
      push_tok($urandom_range(1, 4));
      if ($urandom_range(0, 5) != 0) begin
        msg_q = {msg_q, CH_COLON};
        repeat ($urandom_range(0, 2)) msg_q = {msg_q, CH_SPACE};
        push_tok($urandom_range(0, 4));
      end
      if ($urandom_range(0, 9) == 0) push_noise();
      push_eol();
    end
    if ($urandom_range(0, 7) != 0) push_eol();
    repeat ($urandom_range(0, 6)) msg_q = {msg_q, 8'($urandom)};
  endtask

  initial begin
    bit dir;
    bit paused;
    rst_n     = 1'b0;
    in_tvalid = 1'b0;
    in_tdata  = '0;
    in_tuser  = '0;
    in_tlast  = 1'b0;
    quiet     = 1'b0;
    sent      = 0;
    paused    = 1'b0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: stray byte before any message, then a plain exchange.
    send_item(8'hFF, 1'b1, 1'b0, 1'b0, 1'b1);
    push_str("GET / H\r\nA: b\r\n\r\nXY");
    send_msg(1'b0, 1'b0);
    push_str("H 2 O\nA:\nB\n\n");
    send_msg(1'b1, 1'b0);
    // Repeated direction: flagged, rest of that message dropped.
    push_str("H 1 x");
    send_msg(1'b1, 1'b0);
    // HTTP/0.9 request, then an all-body response.
    push_str("G /\n");
    send_msg(1'b0, 1'b0);
    push_str("ab\r");
    send_msg(1'b1, 1'b0);
    // Non-ASCII byte in the start line; empty message; dangling CR.
    msg_q = {msg_q, 8'h47, 8'h80, CH_LF};
    send_msg(1'b0, 1'b0);
    send_msg(1'b1, 1'b0);
    push_str("G a b\r");
    send_msg(1'b0, 1'b0);

    // Random messages; directions mostly alternate.
    dir = 1'b0;
    while (sent < RANDOM_ITEMS) begin
      if (!paused && sent > RANDOM_ITEMS / 2) begin
        // hold the sender until every span is out
        paused = 1'b1;
        in_tvalid <= 1'b0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
      end
      if (sent > RANDOM_ITEMS * 4 / 5) quiet = 1'b1;
      if ($urandom_range(0, 9) != 0) dir = ~dir;
      if ($urandom_range(0, 19) == 0)
        send_item(8'($urandom), 1'($urandom), 1'($urandom), 1'b0, 1'($urandom));
      if ($urandom_range(0, 7) == 0) begin
        // unfinished message cut off by the next first byte
        push_tok($urandom_range(1, 5));
        send_item(msg_q[0], 1'b1, dir, 1'b1, 1'b0);
        msg_q.delete();
        dir = ~dir;
      end
      build_msg(dir);
      send_msg(dir, 1'b1);
    end
    in_tvalid <= 1'b0;

    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fail_count == 0) begin
      $display("[http_message_splitter_top] OK");
    end else begin
      $display("[http_message_splitter_top] ERROR");
    end
    $finish;
  end

endmodule
